@@ rtl/psd_pkg.sv @@
// Shared defaults for the point to segment distance pipeline.
`timescale 1ns / 1ps
package psd_pkg;

  // Default coordinate width (signed Q12.4)
  localparam int unsigned CoordWidthDef = 16;
  // Default fraction bits of the projection parameter t
  localparam int unsigned FracBitsDef   = 16;

endpackage

@@ rtl/psd_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module psd_div #(
  parameter int unsigned NW  = 50,  // numerator and quotient width
  parameter int unsigned DW  = 34,  // divisor width
  parameter int unsigned SBW = 8    // sideband width carried with each transaction
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SBW-1:0] sb_i,
  output logic           valid_o,
  output logic [NW-1:0]  quo_o,
  output logic [SBW-1:0] sb_o
);

  logic           v_q   [NW];
  logic [DW-1:0]  rem_q [NW];
  logic [NW-1:0]  num_q [NW];
  logic [DW-1:0]  den_q [NW];
  logic [NW-1:0]  quo_q [NW];
  logic [SBW-1:0] sb_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic           v_in;
    logic [DW-1:0]  rem_in;
    logic [NW-1:0]  num_in;
    logic [DW-1:0]  den_in;
    logic [NW-1:0]  quo_in;
    logic [SBW-1:0] sb_in;
    logic [DW:0]    cand;
    logic [DW:0]    diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    // bring down the next numerator bit and try the subtract
    assign cand = {rem_in, num_in[NW-1]};
    assign diff = cand - {1'b0, den_in};
    assign ge   = (cand >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[DW-1:0] : cand[DW-1:0];
      num_q[k] <= num_in << 1;
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[NW-2:0], ge};
      sb_q[k]  <= sb_in;
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign sb_o    = sb_q[NW-1];

endmodule

@@ rtl/psd_sqrt.sv @@
// Pipelined floor integer square root, one root bit per register stage.
`timescale 1ns / 1ps
module psd_sqrt #(
  parameter int unsigned RW  = 17,  // root width, radicand is twice as wide
  parameter int unsigned SBW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SBW-1:0]  sb_o
);

  logic            v_q    [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [2*RW-1:0] rad_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [SBW-1:0]  sb_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_in;
    logic [RW+1:0]   rem_in;
    logic [2*RW-1:0] rad_in;
    logic [RW-1:0]   root_in;
    logic [SBW-1:0]  sb_in;
    logic [RW+1:0]   cand;
    logic [RW+1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
      assign sb_in   = sb_q[k-1];
    end

    // remainder stays below 2*root + 1, so its low RW bits hold it
    assign cand  = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cand >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? (cand - trial) : cand;
      rad_q[k]  <= rad_in << 2;
      root_q[k] <= {root_in[RW-2:0], ge};
      sb_q[k]   <= sb_in;
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign sb_o    = sb_q[RW-1];

endmodule

@@ rtl/point_segment_distance.sv @@
// Closest point on a line segment and distance to it, fully pipelined.
//
//   channel   handshake             payload
//   ------    --------------------  ------------------------------------------
//   input     start_i / busy_o      seg_start_x/y, seg_end_x/y, point_x/y, clamp
//   result    done_o (strobe)       closest_x/y, distance, saturated
//
// One transaction is accepted per cycle; busy_o is always low.
// Between input and result lie NQ = 2*COORD_WIDTH + 2 + PARAM_FRAC_BITS divider stages
// and RTW = COORD_WIDTH + 1 square root stages, besides the stages of this module.
// Reset clears only the valid bits; results appear for one cycle and cannot be held.
`timescale 1ns / 1ps
module point_segment_distance #(
  parameter int unsigned COORD_WIDTH     = psd_pkg::CoordWidthDef,
  parameter int unsigned PARAM_FRAC_BITS = psd_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic                          clamp_to_segment_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] closest_x_o,
  output logic signed [COORD_WIDTH-1:0] closest_y_o,
  output logic        [COORD_WIDTH:0]   distance_o,
  output logic                          saturated_o
);

  import psd_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned FB  = PARAM_FRAC_BITS;
  localparam int unsigned AW  = CW + 1;          // coordinate differences
  localparam int unsigned PW2 = 2 * AW;          // squares and dot terms
  localparam int unsigned SW  = PW2 + 1;         // dot product
  localparam int unsigned DW  = 2 * CW + 2;      // |AB|^2 and |dot|
  localparam int unsigned NQ  = DW + FB;         // quotient bits
  localparam int unsigned TW  = CW + FB;         // t
  localparam int unsigned PW  = TW + AW;         // t * AB
  localparam int unsigned MW  = PW + 1 - FB;     // rounded magnitude
  localparam int unsigned XW  = MW + 2;          // A + rounded term
  localparam int unsigned RTW = AW;              // root width
  localparam int unsigned LAT = 10 + NQ + RTW;
  localparam int unsigned DSB = 4 * CW + 2 * AW + 3;
  localparam int unsigned QSB = 2 * CW + 1;

  localparam logic [NQ-1:0] One  = NQ'(1) << FB;
  localparam logic [NQ-1:0] TMin = NQ'(1) << (TW - 1);
  localparam logic [NQ-1:0] TMax = TMin - NQ'(1);
  localparam logic [PW:0]   Half = (PW + 1)'(1) << (FB - 1);
  localparam logic signed [XW-1:0] CMax = {{(XW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [XW-1:0] CMin = {{(XW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // stage 1: segment and point differences
  logic                 v1_q;
  logic signed [CW-1:0] ax1_q, ay1_q, px1_q, py1_q;
  logic signed [AW-1:0] abx1_q, aby1_q, apx1_q, apy1_q;
  logic                 cl1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    ax1_q  <= seg_start_x_i;
    ay1_q  <= seg_start_y_i;
    px1_q  <= point_x_i;
    py1_q  <= point_y_i;
    cl1_q  <= clamp_to_segment_i;
    abx1_q <= AW'(seg_end_x_i) - AW'(seg_start_x_i);
    aby1_q <= AW'(seg_end_y_i) - AW'(seg_start_y_i);
    apx1_q <= AW'(point_x_i) - AW'(seg_start_x_i);
    apy1_q <= AW'(point_y_i) - AW'(seg_start_y_i);
  end

  // stage 2: the four products
  logic                  v2_q;
  logic signed [CW-1:0]  ax2_q, ay2_q, px2_q, py2_q;
  logic signed [AW-1:0]  abx2_q, aby2_q;
  logic                  cl2_q;
  logic signed [PW2-1:0] sqx2_q, sqy2_q, dpx2_q, dpy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax2_q  <= ax1_q;
    ay2_q  <= ay1_q;
    px2_q  <= px1_q;
    py2_q  <= py1_q;
    cl2_q  <= cl1_q;
    abx2_q <= abx1_q;
    aby2_q <= aby1_q;
    sqx2_q <= PW2'(abx1_q) * PW2'(abx1_q);
    sqy2_q <= PW2'(aby1_q) * PW2'(aby1_q);
    dpx2_q <= PW2'(apx1_q) * PW2'(abx1_q);
    dpy2_q <= PW2'(apy1_q) * PW2'(aby1_q);
  end

  // stage 3: |AB|^2, dot product magnitude and sign
  logic signed [SW-1:0] dot;
  logic [DW-1:0]        ab2;
  logic                 v3_q;
  logic [DW-1:0]        ab2_q;
  logic [DW-1:0]        dmag_q;
  logic [DSB-1:0]       sb3_q;

  assign dot = SW'(dpx2_q) + SW'(dpy2_q);
  assign ab2 = DW'($unsigned(sqx2_q)) + DW'($unsigned(sqy2_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ab2_q  <= ab2;
    dmag_q <= dot[SW-1] ? DW'(-dot) : DW'(dot);
    sb3_q  <= {ax2_q, ay2_q, abx2_q, aby2_q, px2_q, py2_q, cl2_q, dot[SW-1],
               (ab2 == '0)};
  end

  // stages 4 to 3+NQ: |dot| * 2^FB / |AB|^2
  logic           vq;
  logic [NQ-1:0]  quo;
  logic [DSB-1:0] sbq;

  psd_div #(
    .NW  (NQ),
    .DW  (DW),
    .SBW (DSB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .num_i   ({dmag_q, {FB{1'b0}}}),
    .den_i   (ab2_q),
    .sb_i    (sb3_q),
    .valid_o (vq),
    .quo_o   (quo),
    .sb_o    (sbq)
  );

  logic signed [CW-1:0] axq, ayq, pxq, pyq;
  logic signed [AW-1:0] abxq, abyq;
  logic                 clq, dnegq, abzq;
  assign {axq, ayq, abxq, abyq, pxq, pyq, clq, dnegq, abzq} = sbq;

  // t stage: zero for a zero-length segment, sign, clamp to [0,1] or saturate
  logic signed [TW-1:0] t_d;
  logic                 st_d;

  always_comb begin
    t_d  = '0;
    st_d = 1'b0;
    priority if (abzq) begin
      t_d = '0;
    end else if (clq) begin
      priority if (dnegq) begin
        t_d = '0;
      end else if (quo > One) begin
        t_d = TW'(One);
      end else begin
        t_d = TW'(quo);
      end
    end else if (dnegq) begin
      priority if (quo > TMin) begin
        t_d  = TW'(TMin);
        st_d = 1'b1;
      end else begin
        t_d = -TW'(quo);
      end
    end else if (quo > TMax) begin
      t_d  = TW'(TMax);
      st_d = 1'b1;
    end else begin
      t_d = TW'(quo);
    end
  end

  logic                 vt_q;
  logic signed [TW-1:0] t_q;
  logic                 st_q;
  logic signed [CW-1:0] axt_q, ayt_q, pxt_q, pyt_q;
  logic signed [AW-1:0] abxt_q, abyt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
    end else begin
      vt_q <= vq;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    st_q   <= st_d;
    axt_q  <= axq;
    ayt_q  <= ayq;
    pxt_q  <= pxq;
    pyt_q  <= pyq;
    abxt_q <= abxq;
    abyt_q <= abyq;
  end

  // product stage: t * AB
  logic                 vp_q;
  logic signed [PW-1:0] prx_q, pry_q;
  logic                 sp_q;
  logic signed [CW-1:0] axp_q, ayp_q, pxp_q, pyp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= vt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prx_q <= PW'(t_q) * PW'(abxt_q);
    pry_q <= PW'(t_q) * PW'(abyt_q);
    sp_q  <= st_q;
    axp_q <= axt_q;
    ayp_q <= ayt_q;
    pxp_q <= pxt_q;
    pyp_q <= pyt_q;
  end

  // rounding stage: magnitude rounded half away from zero
  logic [PW-1:0]        magx, magy;
  logic [PW:0]          rndx, rndy;
  logic                 vr_q;
  logic [MW-1:0]        rmx_q, rmy_q;
  logic                 nx_q, ny_q, sr_q;
  logic signed [CW-1:0] axr_q, ayr_q, pxr_q, pyr_q;

  assign magx = prx_q[PW-1] ? PW'(-prx_q) : PW'(prx_q);
  assign magy = pry_q[PW-1] ? PW'(-pry_q) : PW'(pry_q);
  assign rndx = ((PW + 1)'(magx) + Half) >> FB;
  assign rndy = ((PW + 1)'(magy) + Half) >> FB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else begin
      vr_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rmx_q <= rndx[MW-1:0];
    rmy_q <= rndy[MW-1:0];
    nx_q  <= prx_q[PW-1];
    ny_q  <= pry_q[PW-1];
    sr_q  <= sp_q;
    axr_q <= axp_q;
    ayr_q <= ayp_q;
    pxr_q <= pxp_q;
    pyr_q <= pyp_q;
  end

  // closest point stage: add to A and saturate
  logic signed [XW-1:0] sumx, sumy;
  logic                 ovx, ovy;
  logic                 vc_q;
  logic signed [CW-1:0] cx_q, cy_q, pxc_q, pyc_q;
  logic                 sc_q;

  assign sumx = XW'(axr_q) + (nx_q ? -XW'(rmx_q) : XW'(rmx_q));
  assign sumy = XW'(ayr_q) + (ny_q ? -XW'(rmy_q) : XW'(rmy_q));
  assign ovx  = (sumx > CMax) || (sumx < CMin);
  assign ovy  = (sumy > CMax) || (sumy < CMin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q  <= (sumx > CMax) ? CW'(CMax) : ((sumx < CMin) ? CW'(CMin) : CW'(sumx));
    cy_q  <= (sumy > CMax) ? CW'(CMax) : ((sumy < CMin) ? CW'(CMin) : CW'(sumy));
    sc_q  <= sr_q || ovx || ovy;
    pxc_q <= pxr_q;
    pyc_q <= pyr_q;
  end

  // offset stage: P - C
  logic                 vd_q;
  logic signed [AW-1:0] dx_q, dy_q;
  logic [QSB-1:0]       sbd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= AW'(pxc_q) - AW'(cx_q);
    dy_q  <= AW'(pyc_q) - AW'(cy_q);
    sbd_q <= {cx_q, cy_q, sc_q};
  end

  // square stage
  logic                  vs_q;
  logic signed [PW2-1:0] ddx_q, ddy_q;
  logic [QSB-1:0]        sbs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else begin
      vs_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ddx_q <= PW2'(dx_q) * PW2'(dx_q);
    ddy_q <= PW2'(dy_q) * PW2'(dy_q);
    sbs_q <= sbd_q;
  end

  // sum stage: squared distance
  logic             vm_q;
  logic [PW2-1:0]   d2_q;
  logic [QSB-1:0]   sbm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else begin
      vm_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q  <= $unsigned(ddx_q) + $unsigned(ddy_q);
    sbm_q <= sbs_q;
  end

  // square root stages; the last one is the result register
  logic [QSB-1:0] sbo;

  psd_sqrt #(
    .RW  (RTW),
    .SBW (QSB)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vm_q),
    .rad_i   (d2_q),
    .sb_i    (sbm_q),
    .valid_o (done_o),
    .root_o  (distance_o),
    .sb_o    (sbo)
  );

  assign {closest_x_o, closest_y_o, saturated_o} = sbo;

`ifndef SYNTHESIS
  // every accepted transaction yields exactly one result
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted transaction produced no result");

  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without an accepted transaction");

  // an item inside the divider always has a valid bit at its output stage
  a_div_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ##NQ vq)
    else $error("divider lost a transaction");
`endif

endmodule
